### src/forms_pkg.sv
package forms_pkg;

    localparam int REG_FIELD_W = 3;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_SET = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_JNZ = 2'd3
    } t_op;

    localparam logic CFG_PROG_LEN = 1'b0;

    typedef struct packed {
        logic [1:0]             req_type;
        logic                   first_is_imm;
        logic [REG_FIELD_W-1:0] first_reg;
        logic signed [63:0]     first_imm;
        logic                   second_is_imm;
        logic [REG_FIELD_W-1:0] second_reg;
        logic signed [63:0]     second_imm;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] next_pc;
        logic               halted;
        logic [31:0]        mul_total;
        logic signed [63:0] dest_value;
    } t_out_item;

    typedef struct packed {
        t_op                    op;
        logic                   test_is_imm;
        logic                   src_is_imm;
        logic [REG_FIELD_W-1:0] a_reg;
        logic [REG_FIELD_W-1:0] b_reg;
        logic [63:0]            test_imm;
        logic [63:0]            src_imm;
    } t_uop;

    typedef struct packed {
        logic push;
    } t_q_ctrl;

endpackage

### src/forms_front.sv
module forms_front (
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  forms_pkg::t_in_item i_in_item,
    input  logic                i_q_full,
    output forms_pkg::t_q_ctrl  o_q_ctrl,
    output forms_pkg::t_uop     o_uop
);
    import forms_pkg::*;

    t_op op;

    assign op         = t_op'(i_in_item.req_type);
    assign o_in_stall = i_q_full;

    always_comb begin
        o_q_ctrl.push = i_in_valid && !i_q_full;
    end

    // destination-as-immediate only matters for the jump test
    always_comb begin
        o_uop.op          = op;
        o_uop.test_is_imm = (op == OP_JNZ) && i_in_item.first_is_imm;
        o_uop.src_is_imm  = i_in_item.second_is_imm;
        o_uop.a_reg       = i_in_item.first_reg;
        o_uop.b_reg       = i_in_item.second_reg;
        o_uop.test_imm    = i_in_item.first_imm;
        o_uop.src_imm     = i_in_item.second_imm;
    end

endmodule

### src/forms_queue.sv
module forms_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  forms_pkg::t_q_ctrl i_ctrl,
    input  forms_pkg::t_uop    i_uop,
    output logic               o_full,
    output logic               o_valid,
    output forms_pkg::t_uop    o_uop,
    input  logic               i_pop
);
    import forms_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_uop             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             pop;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_uop   = r_mem[r_rp];
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (i_ctrl.push && !pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (pop && !i_ctrl.push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_ctrl.push) begin
                r_wp <= r_wp + PTR_W'(1);
            end
            if (pop) begin
                r_rp <= r_rp + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[r_wp] <= i_uop;
        end
    end

endmodule

### src/forms_back.sv
module forms_back #(
    parameter int NUM_REGS    = 8,
    parameter int MAX_PROGRAM = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_uop_valid,
    input  forms_pkg::t_uop      i_uop,
    output logic                 o_uop_pop,
    input  logic [10:0]          i_prog_len,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output forms_pkg::t_out_item o_out_item
);
    import forms_pkg::*;

    localparam int RW = $clog2(NUM_REGS);

    function automatic logic [RW-1:0] f_pick(input logic [REG_FIELD_W-1:0] idx);
        logic [RW-1:0] r;
        r = '0;
        for (int k = 0; k < (1 << REG_FIELD_W); k++) begin
            if (idx == REG_FIELD_W'(k)) begin
                r = RW'(k % NUM_REGS);
            end
        end
        return r;
    endfunction

    logic [63:0]         r_mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_vld;

    logic        r_e_valid;
    t_uop        r_e_uop;
    logic        r_mul_phase;
    logic [63:0] r_rd_a;
    logic [63:0] r_rd_b;
    logic        r_vld_a;
    logic        r_vld_b;
    logic        r_fwd_a;
    logic        r_fwd_b;
    logic [63:0] r_fwd_data;
    logic [63:0] r_pp_ll;
    logic [31:0] r_pp_hl;
    logic [31:0] r_pp_lh;
    logic [31:0] r_pc;
    logic [31:0] r_mul_cnt;
    logic        r_out_valid;
    t_out_item   r_out_item;

    logic [RW-1:0] ia;
    logic [RW-1:0] ib;
    logic [RW-1:0] wd;
    logic [63:0]   a_val;
    logic [63:0]   b_val;
    logic [63:0]   src;
    logic [63:0]   test;
    logic [63:0]   m_ll;
    logic [31:0]   m_hl;
    logic [31:0]   m_lh;
    logic [63:0]   product;
    logic [63:0]   written;
    logic [31:0]   n_pc;
    logic [31:0]   n_mul_cnt;
    logic [31:0]   len_ext;
    logic [31:0]   eff_len;
    logic          halt;
    logic          done;
    logic          load;
    logic          wr_en;

    assign ia = f_pick(i_uop.a_reg);
    assign ib = f_pick(i_uop.b_reg);
    assign wd = f_pick(r_e_uop.a_reg);

    // forwarding covers the write that landed on the same edge as the read
    assign a_val = r_fwd_a ? r_fwd_data : (r_vld_a ? r_rd_a : 64'd0);
    assign b_val = r_fwd_b ? r_fwd_data : (r_vld_b ? r_rd_b : 64'd0);
    assign src   = r_e_uop.src_is_imm ? r_e_uop.src_imm : b_val;
    assign test  = r_e_uop.test_is_imm ? r_e_uop.test_imm : a_val;

    // low 64 bits of the product from three partial products
    assign m_ll    = a_val[31:0] * src[31:0];
    assign m_hl    = a_val[63:32] * src[31:0];
    assign m_lh    = a_val[31:0] * src[63:32];
    assign product = r_pp_ll + {r_pp_hl + r_pp_lh, 32'd0};

    assign done = r_e_valid && (r_e_uop.op != OP_MUL || r_mul_phase)
                  && (!r_out_valid || !i_out_stall);
    assign load      = i_uop_valid && (!r_e_valid || done);
    assign o_uop_pop = load;
    assign wr_en     = done && (r_e_uop.op != OP_JNZ);

    always_comb begin
        written   = 64'd0;
        n_pc      = r_pc + 32'd1;
        n_mul_cnt = r_mul_cnt;
        case (r_e_uop.op)
            OP_SET: begin
                written = src;
            end
            OP_SUB: begin
                written = a_val - src;
            end
            OP_MUL: begin
                written = product;
                if (r_mul_cnt != 32'hFFFF_FFFF) begin
                    n_mul_cnt = r_mul_cnt + 32'd1;
                end
            end
            OP_JNZ: begin
                if (test != 64'd0) begin
                    n_pc = r_pc + src[31:0];
                end
            end
            default: begin
                written = 64'd0;
            end
        endcase
    end

    assign len_ext = 32'(i_prog_len);
    assign eff_len = (len_ext > 32'(MAX_PROGRAM)) ? 32'(MAX_PROGRAM) : len_ext;
    assign halt    = n_pc[31] || (n_pc >= eff_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid   <= 1'b0;
            r_mul_phase <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc        <= 32'd0;
            r_mul_cnt   <= 32'd0;
            r_vld       <= '0;
            r_vld_a     <= 1'b0;
            r_vld_b     <= 1'b0;
            r_fwd_a     <= 1'b0;
            r_fwd_b     <= 1'b0;
        end else begin
            if (load) begin
                r_e_valid <= 1'b1;
            end else if (done) begin
                r_e_valid <= 1'b0;
            end
            if (done) begin
                r_mul_phase <= 1'b0;
            end else if (r_e_valid && r_e_uop.op == OP_MUL) begin
                r_mul_phase <= 1'b1;
            end
            r_out_valid <= done || (r_out_valid && i_out_stall);
            if (done) begin
                r_pc      <= n_pc;
                r_mul_cnt <= n_mul_cnt;
            end
            if (wr_en) begin
                r_vld[wd] <= 1'b1;
            end
            if (load) begin
                r_vld_a <= r_vld[ia];
                r_vld_b <= r_vld[ib];
                r_fwd_a <= wr_en && (wd == ia);
                r_fwd_b <= wr_en && (wd == ib);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wd]  <= written;
            r_fwd_data <= written;
        end
        if (load) begin
            r_e_uop <= i_uop;
            r_rd_a  <= r_mem[ia];
            r_rd_b  <= r_mem[ib];
        end
        if (r_e_valid && r_e_uop.op == OP_MUL && !r_mul_phase) begin
            r_pp_ll <= m_ll;
            r_pp_hl <= m_hl;
            r_pp_lh <= m_lh;
        end
        if (done) begin
            r_out_item.next_pc    <= n_pc;
            r_out_item.halted     <= halt;
            r_out_item.mul_total  <= n_mul_cnt;
            r_out_item.dest_value <= written;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_mul_two_cycles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e_valid && r_e_uop.op == OP_MUL && !r_mul_phase) |-> !done)
        else $error("multiply completed before its partial products were registered");

    a_mul_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && r_e_uop.op == OP_MUL) |=>
            (r_mul_cnt == $past(r_mul_cnt) + 32'd1 || $past(r_mul_cnt) == 32'hFFFF_FFFF))
        else $error("multiply count did not advance");

    a_pc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !done |=> $stable(r_pc) && $stable(r_mul_cnt))
        else $error("machine state changed without a completed item");

endmodule

### src/four_op_register_machine_step_core.sv
// Executes one pre-decoded set, subtract, multiply or jump-if-nonzero item per cycle,
// unless a multiply or an output stall holds it, and returns the new pc, halt flag,
// saturating multiply count and written value. Items pass through a two-entry queue into
// a single execute stage, which takes a new item as the last completes; a multiply there
// takes an extra step (three 32x32 partial products are registered, then summed).
// An accepted item is registered in the queue, then in execute, and its result at the
// output. The register file is cleared at reset by per-entry valid bits, so no clearing
// pass is needed. program_length is at APB byte address 0.
module four_op_register_machine_step_core #(
    parameter int NUM_REGS    = 8,
    parameter int MAX_PROGRAM = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  forms_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output forms_pkg::t_out_item o_out_item,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import forms_pkg::*;

    logic [10:0] r_prog_len;
    t_q_ctrl     q_ctrl;
    t_uop        front_uop;
    t_uop        head_uop;
    logic        q_full;
    logic        q_valid;
    logic        q_pop;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_PROG_LEN) ? {21'd0, r_prog_len} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_len <= 11'd1;
        end else if (psel && penable && pwrite && pready && paddr[2] == CFG_PROG_LEN) begin
            r_prog_len <= pwdata[10:0];
        end
    end

    forms_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_q_ctrl   (q_ctrl),
        .o_uop      (front_uop)
    );

    forms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (q_ctrl),
        .i_uop   (front_uop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_uop   (head_uop),
        .i_pop   (q_pop)
    );

    forms_back #(
        .NUM_REGS    (NUM_REGS),
        .MAX_PROGRAM (MAX_PROGRAM)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uop_valid (q_valid),
        .i_uop       (head_uop),
        .o_uop_pop   (q_pop),
        .i_prog_len  (r_prog_len),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

### tb/tb_four_op_register_machine_step_core.sv
`timescale 1ns / 100ps

module tb_four_op_register_machine_step_core;
    import forms_pkg::*;

    localparam int NREGS       = 8;
    localparam int PROG_MAX    = 1024;
    localparam int PRINT_LIMIT = 40;

    class machine_tracker;
        logic [63:0] regs [NREGS];
        logic [31:0] pc;
        logic [31:0] mul_count;
        logic [10:0] prog_len;
        t_out_item   expected_steps[$];
        int          errors;

        function new();
            foreach (regs[i]) regs[i] = '0;
            pc        = '0;
            mul_count = '0;
            prog_len  = 11'd1;
            errors    = 0;
        endfunction

        task report(string msg);
            if (errors < PRINT_LIMIT) $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function int unsigned pc_limit();
            return (prog_len > PROG_MAX) ? PROG_MAX : int'(prog_len);
        endfunction

        function void note_instr(t_in_item it);
            t_out_item   r;
            logic [63:0] src;
            logic [63:0] test;
            logic [63:0] written;
            logic [2:0]  d;
            d       = it.first_reg;
            src     = it.second_is_imm ? it.second_imm : regs[it.second_reg];
            written = '0;
            case (t_op'(it.req_type))
                OP_SET: begin
                    written = src;
                    regs[d] = written;
                    pc      = pc + 32'd1;
                end
                OP_SUB: begin
                    written = regs[d] - src;
                    regs[d] = written;
                    pc      = pc + 32'd1;
                end
                OP_MUL: begin
                    written = regs[d] * src;
                    regs[d] = written;
                    pc      = pc + 32'd1;
                    if (mul_count != 32'hFFFF_FFFF) mul_count = mul_count + 32'd1;
                end
                default: begin
                    test = it.first_is_imm ? it.first_imm : regs[d];
                    pc   = (test != '0) ? pc + src[31:0] : pc + 32'd1;
                end
            endcase
            r.next_pc    = pc;
            r.halted     = pc[31] || (pc >= pc_limit());
            r.mul_total  = mul_count;
            r.dest_value = written;
            expected_steps.insert(expected_steps.size(), r);
        endfunction

        task check_step(t_out_item got);
            t_out_item e;
            if (expected_steps.size() == 0) begin
                report($sformatf("result with nothing pending: %p", got));
                return;
            end
            e = expected_steps.pop_front();
            if (got.next_pc !== e.next_pc)
                report($sformatf("next_pc got %h expected %h", got.next_pc, e.next_pc));
            if (got.halted !== e.halted)
                report($sformatf("halted got %b expected %b", got.halted, e.halted));
            if (got.mul_total !== e.mul_total)
                report($sformatf("mul_total got %h expected %h", got.mul_total, e.mul_total));
            if (got.dest_value !== e.dest_value)
                report($sformatf("dest_value got %h expected %h",
                                 got.dest_value, e.dest_value));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n      = 1'b0;
    logic        in_valid     = 1'b0;
    logic        o_in_stall;
    t_in_item    in_item      = '0;
    logic        o_out_valid;
    logic        out_stall    = 1'b0;
    t_out_item   o_out_item;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;

    int          tx_idle_pct  = 0;
    int          rx_stall_pct = 0;
    int          hold_reqs    = 0;
    int          hold_seen    = 0;
    int          hold_left    = 0;

    machine_tracker sb = new();

    four_op_register_machine_step_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // result side: check accepted items, stall at random or for a long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall) sb.check_step(o_out_item);
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = 80;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    function automatic t_in_item mk_instr(t_op op, logic fi, logic [2:0] fr,
                                          logic [63:0] fimm, logic si, logic [2:0] sr,
                                          logic [63:0] simm);
        t_in_item it;
        it.req_type      = op;
        it.first_is_imm  = fi;
        it.first_reg     = fr;
        it.first_imm     = fimm;
        it.second_is_imm = si;
        it.second_reg    = sr;
        it.second_imm    = simm;
        return it;
    endfunction

    function automatic logic [63:0] pick_word();
        logic signed [63:0] v;
        int unsigned        k;
        k = $urandom_range(99);
        if (k < 35) begin
            v = 64'($urandom_range(16));
            v = v - 64'sd8;
        end else if (k < 50) begin
            case ($urandom_range(4))
                0:       v = 64'h8000_0000_0000_0000;
                1:       v = 64'h7FFF_FFFF_FFFF_FFFF;
                2:       v = '0;
                3:       v = '1;
                default: v = 64'd1;
            endcase
        end else begin
            v = {$urandom, $urandom};
        end
        return v;
    endfunction

    // jump offsets mostly land back inside the program so halting toggles both ways
    function automatic logic [63:0] pick_offset();
        int unsigned lim;
        logic [31:0] target;
        lim = sb.pc_limit();
        if (lim == 0) lim = 8;
        if ($urandom_range(99) < 60) begin
            target = $urandom_range(lim + 1);
            target = target - 32'd1;
            return {$urandom, target - sb.pc};
        end
        return pick_word();
    endfunction

    function automatic t_in_item random_instr();
        t_in_item it;
        it.req_type      = 2'($urandom_range(3));
        it.first_is_imm  = 1'($urandom_range(1));
        it.first_reg     = 3'($urandom_range(7));
        it.second_is_imm = 1'($urandom_range(1));
        it.second_reg    = 3'($urandom_range(7));
        it.first_imm     = ($urandom_range(99) < 30) ? '0 : pick_word();
        it.second_imm    = (t_op'(it.req_type) == OP_JNZ) ? pick_offset() : pick_word();
        return it;
    endfunction

    task automatic send_instr(input t_in_item it);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_instr(it);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_steps.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_len(input logic [10:0] len);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * int'(CFG_PROG_LEN));
        pwdata  <= {21'd0, len};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.prog_len = len;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_phase(input logic [10:0] len, input int tx, input int rx,
                             input int n, input bit hold_off, input bit pausing);
        drain();
        write_len(len);
        tx_idle_pct  = tx;
        rx_stall_pct = rx;
        for (int i = 0; i < n; i++) begin
            if (hold_off && (i % 120) == 30) hold_reqs <= hold_reqs + 1;
            if (pausing && (i % 50) == 49) drain();
            send_instr(random_instr());
        end
    endtask

    task automatic directed_items();
        send_instr(mk_instr(OP_SET, 1'b0, 3'd0, '0, 1'b1, 3'd0, 64'h7FFF_FFFF_FFFF_FFFF));
        send_instr(mk_instr(OP_SET, 1'b1, 3'd1, '1, 1'b1, 3'd5, 64'h8000_0000_0000_0000));
        send_instr(mk_instr(OP_SET, 1'b0, 3'd7, '0, 1'b1, 3'd0, '1));
        send_instr(mk_instr(OP_SUB, 1'b0, 3'd7, '0, 1'b0, 3'd7, '0));
        send_instr(mk_instr(OP_SUB, 1'b1, 3'd1, '0, 1'b1, 3'd0, 64'd1));
        send_instr(mk_instr(OP_MUL, 1'b0, 3'd0, '0, 1'b1, 3'd0, 64'd2));
        send_instr(mk_instr(OP_MUL, 1'b0, 3'd2, '0, 1'b0, 3'd1, '0));
        send_instr(mk_instr(OP_SET, 1'b0, 3'd3, '0, 1'b1, 3'd0, {32{2'b01}}));
        send_instr(mk_instr(OP_SET, 1'b0, 3'd4, '0, 1'b0, 3'd3, '1));
        send_instr(mk_instr(OP_JNZ, 1'b1, 3'd0, '0, 1'b1, 3'd0, 64'd100));
        send_instr(mk_instr(OP_JNZ, 1'b0, 3'd7, '1, 1'b1, 3'd0, 64'd100));
        send_instr(mk_instr(OP_JNZ, 1'b1, 3'd0, 64'd1, 1'b1, 3'd0,
                            {32'hFFFF_FFFF, 32'd0 - sb.pc - 32'd1}));
        send_instr(mk_instr(OP_JNZ, 1'b1, 3'd0, '1, 1'b1, 3'd0, 64'h7FFF_FFFF_FFFF_FFFF));
        send_instr(mk_instr(OP_JNZ, 1'b1, 3'd0, 64'h8000_0000_0000_0000, 1'b1, 3'd0,
                            64'h0000_0000_8000_0000));
        send_instr(mk_instr(OP_JNZ, 1'b0, 3'd0, '0, 1'b0, 3'd3, '0));
        send_instr(mk_instr(OP_JNZ, 1'b1, 3'd7, 64'd5, 1'b1, 3'd0, {32'd0, 32'd0 - sb.pc}));
        send_instr(mk_instr(OP_SET, 1'b0, 3'd5, '0, 1'b1, 3'd0, {32{2'b10}}));
        send_instr(mk_instr(OP_MUL, 1'b1, 3'd5, '1, 1'b1, 3'd0, 64'h8000_0000_0000_0000));
        send_instr(mk_instr(OP_SUB, 1'b0, 3'd6, '0, 1'b1, 3'd0, 64'h7FFF_FFFF_FFFF_FFFF));
        send_instr(mk_instr(OP_MUL, 1'b0, 3'd6, '0, 1'b0, 3'd6, '0));
        send_instr(mk_instr(OP_JNZ, 1'b1, 3'd4, '0, 1'b1, 3'd0, 64'd7));
        // sequential step from the top positive pc wraps negative
        send_instr(mk_instr(OP_JNZ, 1'b1, 3'd0, 64'd1, 1'b1, 3'd0,
                            {32'd0, 32'h7FFF_FFFF - sb.pc}));
        send_instr(mk_instr(OP_SET, 1'b0, 3'd2, '0, 1'b1, 3'd0, 64'd42));
        send_instr(mk_instr(OP_JNZ, 1'b0, 3'd2, '0, 1'b1, 3'd0, {32'd0, 32'd0 - sb.pc}));
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_items();
        run_phase(11'd1024, 0, 0, 255, 1'b0, 1'b0);
        run_phase(11'd0, 55, 0, 255, 1'b0, 1'b0);
        run_phase(11'd2047, 0, 55, 255, 1'b0, 1'b0);
        run_phase(11'd1, 23, 23, 255, 1'b0, 1'b0);
        run_phase(11'($urandom_range(1023, 2)), 0, 0, 255, 1'b1, 1'b0);
        run_phase(11'd1024, 23, 23, 255, 1'b0, 1'b1);
        drain();
        repeat (10) @(posedge i_clk);
        if (sb.expected_steps.size() != 0) sb.report("results still pending at the end");
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
